// ----- hdl/txo_pkg.sv -----
// Shared types, constants and the font table for the text to display column stream.
// Used by txo_cursor, txo_serial and the top level. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package txo_pkg;

    localparam int unsigned PAGE_W   = 4;
    localparam int unsigned COLUMN_W = 7;
    localparam int unsigned COUNT_W  = 8;
    localparam int unsigned BEAT_W   = 4;

    localparam logic [7:0] CMD_PAGE   = 8'hB0;
    localparam logic [7:0] CMD_COL_HI = 8'h10;
    localparam logic [7:0] CODE_END   = 8'h00;
    localparam logic [7:0] CODE_FIRST = 8'h20;
    localparam logic [7:0] CODE_LAST  = 8'h7F;

    localparam logic [7:0] ADVANCE   = 8'd6;
    localparam logic [7:0] WRAP_AT   = 8'd123;
    localparam logic [3:0] LAST_PAGE = 4'd7;

    localparam logic [BEAT_W-1:0] BEAT_PAGE   = 4'd0;
    localparam logic [BEAT_W-1:0] BEAT_COL_LO = 4'd1;
    localparam logic [BEAT_W-1:0] BEAT_COL_HI = 4'd2;
    localparam logic [BEAT_W-1:0] BEAT_GLYPH  = 4'd3;
    localparam logic [BEAT_W-1:0] BEAT_SPACER = 4'd8;

    localparam logic KIND_BEGIN = 1'b0;
    localparam logic KIND_CHAR  = 1'b1;

    typedef enum logic [2:0] {
        GLYPH_BLANK,
        GLYPH_A,
        GLYPH_B,
        GLYPH_C,
        GLYPH_H,
        GLYPH_E_LOWER,
        GLYPH_L_LOWER,
        GLYPH_O_LOWER
    } glyph_t;

    typedef struct packed {
        logic                valid;
        logic [PAGE_W-1:0]   page;
        logic [COLUMN_W-1:0] column;
        glyph_t              glyph;
    } job_t;

    function automatic logic [7:0] glyph_column(glyph_t g, logic [2:0] idx);
        logic [39:0] cols;
        logic [7:0]  result;
        unique case (g)
            GLYPH_A:       cols = 40'h7C_12_11_12_7C;
            GLYPH_B:       cols = 40'h7F_49_49_49_36;
            GLYPH_C:       cols = 40'h3E_41_41_41_22;
            GLYPH_H:       cols = 40'h7F_08_08_08_7F;
            GLYPH_E_LOWER: cols = 40'h3E_49_49_49_26;
            GLYPH_L_LOWER: cols = 40'h00_41_7F_40_00;
            GLYPH_O_LOWER: cols = 40'h3E_41_41_41_3E;
            default:       cols = 40'h0;
        endcase
        unique case (idx)
            3'd0:    result = cols[39:32];
            3'd1:    result = cols[31:24];
            3'd2:    result = cols[23:16];
            3'd3:    result = cols[15:8];
            3'd4:    result = cols[7:0];
            default: result = 8'h00;
        endcase
        return result;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/txo_cursor.sv -----
// Cursor state and character decode: takes input words, updates the cursor and
// hands one rendering job per drawn character to txo_serial. Depends on txo_pkg.
`timescale 1ns / 1ps
`default_nettype none

module txo_cursor #(
    parameter int unsigned MAX_CHARS = 128
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [2:0]                    start_page,
    input  wire logic [txo_pkg::COLUMN_W-1:0]  start_column,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          in_kind,
    input  wire logic [7:0]                    in_code,
    input  wire logic                          job_take,
    output txo_pkg::job_t                      job
);

    logic [txo_pkg::PAGE_W-1:0]   page_reg, page_next;
    logic [txo_pkg::COLUMN_W-1:0] column_reg, column_next;
    logic                         stopped_reg, stopped_next;
    logic [txo_pkg::COUNT_W-1:0]  count_reg, count_next;
    txo_pkg::job_t                job_reg, job_next;

    logic                         accept;
    logic                         draw;
    txo_pkg::glyph_t              glyph;
    logic [7:0]                   column_adv;
    logic [txo_pkg::PAGE_W-1:0]   page_inc;
    logic [txo_pkg::COUNT_W-1:0]  count_inc;

    assign in_ready = !job_reg.valid || job_take;
    assign accept   = in_valid && in_ready;
    assign job      = job_reg;

    always_comb begin
        unique case (in_code)
            8'h41:   glyph = txo_pkg::GLYPH_A;
            8'h42:   glyph = txo_pkg::GLYPH_B;
            8'h43:   glyph = txo_pkg::GLYPH_C;
            8'h48:   glyph = txo_pkg::GLYPH_H;
            8'h65:   glyph = txo_pkg::GLYPH_E_LOWER;
            8'h6C:   glyph = txo_pkg::GLYPH_L_LOWER;
            8'h6F:   glyph = txo_pkg::GLYPH_O_LOWER;
            default: glyph = txo_pkg::GLYPH_BLANK;
        endcase
    end

    assign column_adv = {1'b0, column_reg} + txo_pkg::ADVANCE;
    assign page_inc   = page_reg + 4'd1;
    assign count_inc  = count_reg + 8'd1;
    assign draw       = (in_kind == txo_pkg::KIND_CHAR) && !stopped_reg
                        && (in_code != txo_pkg::CODE_END);

    always_comb begin
        page_next    = page_reg;
        column_next  = column_reg;
        stopped_next = stopped_reg;
        count_next   = count_reg;
        job_next     = job_reg;
        if (job_take) begin
            job_next.valid = 1'b0;
        end
        if (accept) begin
            if (in_kind == txo_pkg::KIND_BEGIN) begin
                page_next    = {1'b0, start_page};
                column_next  = start_column;
                stopped_next = 1'b0;
                count_next   = '0;
            end else if (!stopped_reg && in_code == txo_pkg::CODE_END) begin
                stopped_next = 1'b1;
            end else if (draw) begin
                job_next.valid  = 1'b1;
                job_next.page   = page_reg;
                job_next.column = column_reg;
                job_next.glyph  = glyph;
                if (column_adv >= txo_pkg::WRAP_AT) begin
                    column_next = '0;
                    page_next   = page_inc;
                    if (page_inc > txo_pkg::LAST_PAGE) begin
                        stopped_next = 1'b1;
                    end
                end else begin
                    column_next = column_adv[txo_pkg::COLUMN_W-1:0];
                end
                count_next = count_inc;
                if (count_inc >= txo_pkg::COUNT_W'(MAX_CHARS)) begin
                    stopped_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_reg      <= '0;
            column_reg    <= '0;
            stopped_reg   <= 1'b0;
            count_reg     <= '0;
            job_reg.valid <= 1'b0;
        end else begin
            page_reg      <= page_next;
            column_reg    <= column_next;
            stopped_reg   <= stopped_next;
            count_reg     <= count_next;
            job_reg.valid <= job_next.valid;
        end
        job_reg.page   <= job_next.page;
        job_reg.column <= job_next.column;
        job_reg.glyph  <= job_next.glyph;
    end

endmodule

`default_nettype wire

// ----- hdl/txo_serial.sv -----
// Beat sequencer and output register: turns one rendering job into nine words
// (three cursor commands, five glyph columns, one spacer). Depends on txo_pkg.
`timescale 1ns / 1ps
`default_nettype none

module txo_serial (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire txo_pkg::job_t  job,
    output logic                job_take,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [7:0]          out_payload,
    output logic                out_is_data,
    output logic                out_last
);

    logic                         busy_reg, busy_next;
    logic [txo_pkg::BEAT_W-1:0]   beat_reg, beat_next;
    logic [txo_pkg::PAGE_W-1:0]   page_reg, page_next;
    logic [txo_pkg::COLUMN_W-1:0] column_reg, column_next;
    txo_pkg::glyph_t              glyph_reg, glyph_next;
    logic                         valid_reg, valid_next;
    logic [7:0]                   payload_reg, payload_next;
    logic                         is_data_reg, is_data_next;
    logic                         last_reg, last_next;

    logic                         out_free;
    logic                         last_beat;
    logic [txo_pkg::BEAT_W-1:0]   glyph_idx;
    logic [7:0]                   beat_byte;

    assign out_free  = !valid_reg || out_ready;
    assign last_beat = busy_reg && out_free && (beat_reg == txo_pkg::BEAT_SPACER);
    assign job_take  = job.valid && (!busy_reg || last_beat);
    assign glyph_idx = beat_reg - txo_pkg::BEAT_GLYPH;

    always_comb begin
        if (beat_reg == txo_pkg::BEAT_PAGE) begin
            beat_byte = txo_pkg::CMD_PAGE | {4'h0, page_reg};
        end else if (beat_reg == txo_pkg::BEAT_COL_LO) begin
            beat_byte = {4'h0, column_reg[3:0]};
        end else if (beat_reg == txo_pkg::BEAT_COL_HI) begin
            beat_byte = txo_pkg::CMD_COL_HI | {5'b0, column_reg[6:4]};
        end else if (beat_reg == txo_pkg::BEAT_SPACER) begin
            beat_byte = 8'h00;
        end else begin
            beat_byte = txo_pkg::glyph_column(glyph_reg, glyph_idx[2:0]);
        end
    end

    always_comb begin
        busy_next    = busy_reg;
        beat_next    = beat_reg;
        page_next    = page_reg;
        column_next  = column_reg;
        glyph_next   = glyph_reg;
        valid_next   = valid_reg;
        payload_next = payload_reg;
        is_data_next = is_data_reg;
        last_next    = last_reg;
        if (out_free) begin
            valid_next = busy_reg;
            if (busy_reg) begin
                payload_next = beat_byte;
                is_data_next = (beat_reg >= txo_pkg::BEAT_GLYPH);
                last_next    = (beat_reg == txo_pkg::BEAT_SPACER);
                if (beat_reg == txo_pkg::BEAT_SPACER) begin
                    busy_next = 1'b0;
                end else begin
                    beat_next = beat_reg + 4'd1;
                end
            end
        end
        if (job_take) begin
            busy_next   = 1'b1;
            beat_next   = txo_pkg::BEAT_PAGE;
            page_next   = job.page;
            column_next = job.column;
            glyph_next  = job.glyph;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            beat_reg  <= txo_pkg::BEAT_PAGE;
            valid_reg <= 1'b0;
        end else begin
            busy_reg  <= busy_next;
            beat_reg  <= beat_next;
            valid_reg <= valid_next;
        end
        page_reg    <= page_next;
        column_reg  <= column_next;
        glyph_reg   <= glyph_next;
        payload_reg <= payload_next;
        is_data_reg <= is_data_next;
        last_reg    <= last_next;
    end

    assign out_valid   = valid_reg;
    assign out_payload = payload_reg;
    assign out_is_data = is_data_reg;
    assign out_last    = last_reg;

endmodule

`default_nettype wire

// ----- hdl/text_to_oled_column_stream.sv -----
// Usage
// The slave stream takes one word per character: tuser is the kind (0 starts a
// new string, 1 is a character) and tdata the character code. A start word loads
// the cursor from the start_page and start_column registers. A drawn character
// yields nine master words: page select, low column and high column commands
// (tuser 0), then five glyph columns and one blank spacer (tuser 1, tlast on the
// spacer). A zero code, a page past 7 or MAX_CHARS drawn characters stop output
// until the next start word. The registers sit on the APB port at 0x0 and 0x4;
// they are to be written only while the block is idle; the block does not enforce it.
// An accepted character passes through the job register and the sequencer's
// beat state before its first word is registered at the output. The nine-beat
// sequencer sets the character rate; start, zero and suppressed words give no
// output. One character waits in a job register while the previous one plays out.
// A stall on m_tready holds the output word and, once the job register is full,
// drops s_tready. Synchronous reset clears the cursor, the registers and all
// valid flags.
// Depends on txo_pkg, txo_cursor and txo_serial.
`timescale 1ns / 1ps
`default_nettype none

module text_to_oled_column_stream #(
    parameter int unsigned MAX_CHARS = 128
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_code
    input  wire logic        s_tuser,   // [0] kind
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] payload
    output logic             m_tuser,   // [0] is_data
    output logic             m_tlast
);

    logic [2:0]                   start_page_reg, start_page_next;
    logic [txo_pkg::COLUMN_W-1:0] start_column_reg, start_column_next;
    logic                         cfg_write;
    txo_pkg::job_t                job;
    logic                         job_take;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        start_page_next   = start_page_reg;
        start_column_next = start_column_reg;
        if (cfg_write) begin
            if (paddr[2]) begin
                start_column_next = pwdata[txo_pkg::COLUMN_W-1:0];
            end else begin
                start_page_next = pwdata[2:0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[1:0] == 2'b00) begin
            if (paddr[2]) begin
                prdata = {25'b0, start_column_reg};
            end else begin
                prdata = {29'b0, start_page_reg};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_page_reg   <= '0;
            start_column_reg <= '0;
        end else begin
            start_page_reg   <= start_page_next;
            start_column_reg <= start_column_next;
        end
    end

    txo_cursor #(
        .MAX_CHARS(MAX_CHARS)
    ) u_cursor (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start_page   (start_page_reg),
        .start_column (start_column_reg),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_kind      (s_tuser),
        .in_code      (s_tdata),
        .job_take     (job_take),
        .job          (job)
    );

    txo_serial u_serial (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .job         (job),
        .job_take    (job_take),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_payload (m_tdata),
        .out_is_data (m_tuser),
        .out_last    (m_tlast)
    );

endmodule

`default_nettype wire

// ----- hdl/txo_checker.sv -----
// Port-level checks for text_to_oled_column_stream, attached by a bind statement.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module txo_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tuser,
    input wire logic       m_tlast
);

    // The master side comes up empty after reset.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output word valid right after reset");

    // A stalled word keeps its content.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled output word changed");

    // The spacer closing a character is a blank data column.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser && m_tdata == 8'h00)
        else $error("last word of a character is not a blank data column");

    // Command words are page select, low column or high column commands.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> !m_tlast && (m_tdata[7:4] == 4'hB
            || m_tdata[7:4] == 4'h0 || (m_tdata[7:4] == 4'h1 && !m_tdata[3])))
        else $error("malformed cursor command word");

endmodule

bind text_to_oled_column_stream txo_checker u_txo_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
